FILE: rtl/hvn_pkg.sv
// shared constants and helpers for the hashed value noise unit
package hvn_pkg;

  localparam int unsigned COORD_FRAC_BITS = 16;

  localparam int unsigned FracDown = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
  localparam int unsigned FracUp   = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
  localparam logic [31:0] FracMask = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);

  localparam logic [31:0] HashMulA = 32'h7feb352d;
  localparam logic [31:0] HashMulB = 32'h846ca68b;
  localparam logic [31:0] RowSalt  = 32'h517cc1b7;
  localparam logic [31:0] SeedReset = 32'd1;

  // edges from input transfer to result transfer
  localparam int unsigned Latency = 8;

  function automatic logic [31:0] cell_of(logic [31:0] c);
    cell_of = 32'($signed(c) >>> COORD_FRAC_BITS);
  endfunction

  function automatic logic [15:0] frac16_of(logic [31:0] c);
    logic [31:0] f;
    f = c & FracMask;
    frac16_of = 16'((f >> FracDown) << FracUp);
  endfunction

endpackage

FILE: rtl/hvn_hash.sv
// two-stage pipelined xorshift-multiply 32-bit hash
module hvn_hash (
  input  logic        clk_i,
  input  logic [31:0] key_i,
  output logic [31:0] hash_o
);

  logic [31:0] mul_a_q, mul_a_d;
  logic [31:0] mul_b_q, mul_b_d;
  logic [31:0] mix_a, mix_b;

  always_comb begin
    mix_a   = key_i ^ (key_i >> 16);
    mul_a_d = mix_a * hvn_pkg::HashMulA;
    mix_b   = mul_a_q ^ (mul_a_q >> 15);
    mul_b_d = mix_b * hvn_pkg::HashMulB;
  end

  always_ff @(posedge clk_i) begin
    mul_a_q <= mul_a_d;
    mul_b_q <= mul_b_d;
  end

  assign hash_o = mul_b_q ^ (mul_b_q >> 16);

endmodule

FILE: rtl/hvn_smooth.sv
// two-stage smoothstep 3t^2 - 2t^3 in q0.16
module hvn_smooth (
  input  logic        clk_i,
  input  logic [15:0] t_i,
  output logic [15:0] s_o
);

  logic [31:0] sq_q, sq_d;
  logic [17:0] k_q, k_d;
  logic [15:0] s_q;
  logic [49:0] prod;

  always_comb begin
    sq_d = t_i * t_i;
    k_d  = 18'd196608 - {1'b0, t_i, 1'b0};
    prod = sq_q * k_q;
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    k_q  <= k_d;
    s_q  <= prod[47:32];
  end

  assign s_o = s_q;

endmodule

FILE: rtl/hvn_blend.sv
// registered linear blend a + floor((b - a) * w / 2^16)
module hvn_blend (
  input  logic        clk_i,
  input  logic [23:0] a_i,
  input  logic [23:0] b_i,
  input  logic [15:0] w_i,
  output logic [23:0] y_o
);

  logic signed [24:0] diff;
  logic signed [41:0] prod;
  logic signed [41:0] sum;
  logic [23:0]        y_q;

  always_comb begin
    diff = $signed({1'b0, b_i}) - $signed({1'b0, a_i});
    prod = 42'(diff) * 42'($signed({1'b0, w_i}));
    sum  = $signed({18'd0, a_i}) + (prod >>> 16);
  end

  always_ff @(posedge clk_i) begin
    y_q <= sum[23:0];
  end

  assign y_o = y_q;

endmodule

FILE: rtl/hashed_value_noise_2d_unit.sv
// top level of the 2-d hashed value noise pipeline
//
// channel   | direction | signals                            | transfer
// ----------+-----------+------------------------------------+---------------------
// point     | in        | point_x_i, point_y_i               | start_i && !busy_o
// noise     | out       | noise_value_o                      | done_o, one cycle
// seed reg  | in        | cfg_wdata_i                        | cfg_we_i
//
// one point per cycle, each result strobed on done_o after its transfer
// latency is set by the cell stage, two chained two-stage hashes, the score register
// and the two blend stages
// busy_o stays low: there is no backpressure and the pipeline never stalls
// reset clears the valid bits and sets the seed to 1
module hashed_value_noise_2d_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [23:0] noise_value_o
);

  localparam int unsigned Lat = hvn_pkg::Latency;

  logic [31:0]    seed_q;
  logic [Lat-1:0] valid_q;

  logic [31:0] col0_q, col1_q, row0_q, row1_q;
  logic [15:0] tx_q, ty_q;
  logic [31:0] cx, cy;

  logic [31:0] hcol0, hcol1, hrow0, hrow1;
  logic [31:0] h00, h10, h01, h11;
  logic [15:0] u3, v3;
  logic [15:0] u4_q, v4_q, u5_q, v5_q, u6_q, v6_q, v7_q;
  logic [23:0] sc00_q, sc10_q, sc01_q, sc11_q;
  logic [23:0] top, bot;

  assign busy_o = 1'b0;
  assign cx = hvn_pkg::cell_of(point_x_i);
  assign cy = hvn_pkg::cell_of(point_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= hvn_pkg::SeedReset;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      valid_q <= {valid_q[Lat-2:0], start_i & ~busy_o};
    end
  end

  // stage 1: lattice cell and offsets
  always_ff @(posedge clk_i) begin
    col0_q <= cx;
    col1_q <= cx + 32'd1;
    row0_q <= cy + hvn_pkg::RowSalt;
    row1_q <= cy + 32'd1 + hvn_pkg::RowSalt;
    tx_q   <= hvn_pkg::frac16_of(point_x_i);
    ty_q   <= hvn_pkg::frac16_of(point_y_i);
  end

  // stages 2-3: axis hashes and smoothstep
  hvn_hash u_hcol0 (.clk_i, .key_i(col0_q), .hash_o(hcol0));
  hvn_hash u_hcol1 (.clk_i, .key_i(col1_q), .hash_o(hcol1));
  hvn_hash u_hrow0 (.clk_i, .key_i(row0_q), .hash_o(hrow0));
  hvn_hash u_hrow1 (.clk_i, .key_i(row1_q), .hash_o(hrow1));

  hvn_smooth u_smx (.clk_i, .t_i(tx_q), .s_o(u3));
  hvn_smooth u_smy (.clk_i, .t_i(ty_q), .s_o(v3));

  // stages 4-5: corner hashes
  hvn_hash u_h00 (.clk_i, .key_i(seed_q ^ hcol0 ^ hrow0), .hash_o(h00));
  hvn_hash u_h10 (.clk_i, .key_i(seed_q ^ hcol1 ^ hrow0), .hash_o(h10));
  hvn_hash u_h01 (.clk_i, .key_i(seed_q ^ hcol0 ^ hrow1), .hash_o(h01));
  hvn_hash u_h11 (.clk_i, .key_i(seed_q ^ hcol1 ^ hrow1), .hash_o(h11));

  // stage 6: corner scores, weights delayed alongside
  always_ff @(posedge clk_i) begin
    u4_q   <= u3;
    v4_q   <= v3;
    u5_q   <= u4_q;
    v5_q   <= v4_q;
    u6_q   <= u5_q;
    v6_q   <= v5_q;
    v7_q   <= v6_q;
    sc00_q <= h00[31:8];
    sc10_q <= h10[31:8];
    sc01_q <= h01[31:8];
    sc11_q <= h11[31:8];
  end

  // stage 7: horizontal blends, stage 8: vertical blend
  hvn_blend u_top (.clk_i, .a_i(sc00_q), .b_i(sc10_q), .w_i(u6_q), .y_o(top));
  hvn_blend u_bot (.clk_i, .a_i(sc01_q), .b_i(sc11_q), .w_i(u6_q), .y_o(bot));
  hvn_blend u_ver (.clk_i, .a_i(top), .b_i(bot), .w_i(v7_q), .y_o(noise_value_o));

  assign done_o = valid_q[Lat-1];

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (valid_q[0] == $past(start_i)))
    else $error("pipeline entry bit does not follow the input transfer");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(valid_q[0], Lat - 1))
    else $error("result strobe without a matching input transfer");

endmodule
